### rtl/fbpa_pkg.sv
`timescale 1ns / 1ps

package fbpa_pkg;

  localparam int BLOCKS = 64;
  localparam int IDX_W = $clog2(BLOCKS);
  localparam int CNT_W = $clog2(BLOCKS + 1);
  localparam int LINK_W = $clog2(BLOCKS + 2);

  // Link codes beyond the valid block indexes.
  localparam logic [LINK_W-1:0] LINK_TAKEN = LINK_W'(BLOCKS);
  localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(BLOCKS + 1);

  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_PUT = 1'b1;

  localparam logic [1:0] STAT_OK = 2'd0;
  localparam logic [1:0] STAT_MARGIN = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [LINK_W-1:0] data;
  } mem_wr_t;

  // Link held by an entry that has not been written since reset.
  function automatic logic [LINK_W-1:0] reset_link(input logic [IDX_W-1:0] addr);
    logic [LINK_W-1:0] res;
    if (addr == IDX_W'(BLOCKS - 1)) begin
      res = LINK_NONE;
    end else begin
      res = LINK_W'(addr) + LINK_W'(1);
    end
    return res;
  endfunction

endpackage

### rtl/fixed_block_pool_allocator_core.sv
`timescale 1ns / 1ps

// Fixed-block pool allocator with a linked free list in a link memory.
// Request channel (req_valid/req_ready): kind selects get or put, margin is
// the number of blocks a get must leave free, block_index names the block
// returned by a put. Every request yields exactly one response transaction
// on the rsp_valid/rsp_ready channel with granted, block_out, status, the
// free count after the request and the low-water mark since reset.
// A request runs in order: the head's link is read from the synchronous
// link memory, then the list is updated and the response register loaded,
// which makes the response valid. No new request is taken until that
// register has been loaded, as req_ready stays low until then.
// A response waiting in the output register does not block the next
// request; only when the receiver stalls and a second result is ready
// does the block hold that result and keep req_ready low.
// Reset is immediate: all blocks are free and linked in ascending order,
// the head is block 0, and no link memory sweep is needed.
module fixed_block_pool_allocator_core import fbpa_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  logic             kind,
  input  logic [6:0]       margin,
  input  logic [5:0]       block_index,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output logic             granted,
  output logic [5:0]       block_out,
  output logic [1:0]       status,
  output logic [6:0]       free_now,
  output logic [6:0]       min_free
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic              state;
  logic              req_kind;
  logic [6:0]        req_margin;
  logic [IDX_W-1:0]  req_blk;
  logic [IDX_W-1:0]  free_head;
  logic [CNT_W-1:0]  free_count;
  logic [CNT_W-1:0]  low_water;

  logic              accept;
  logic              fire;
  logic [LINK_W-1:0] rd_link;
  mem_wr_t           mem_wr;

  logic              grant;
  logic [1:0]        stat;
  logic [IDX_W-1:0]  blk_res;
  logic [IDX_W-1:0]  free_head_next;
  logic [CNT_W-1:0]  free_count_next;
  logic [CNT_W-1:0]  low_water_next;

  assign req_ready = (state == ST_IDLE);
  assign accept = req_valid && req_ready;
  assign fire = (state == ST_EXEC) && (!rsp_valid || rsp_ready);

  fbpa_link_mem u_link_mem (
    .clk     (clk),
    .rst     (rst),
    .wr      (mem_wr),
    .rd_en   (accept),
    .rd_addr (free_head),
    .rd_link (rd_link)
  );

  always_comb begin
    grant = 1'b0;
    stat = STAT_OK;
    blk_res = '0;
    free_head_next = free_head;
    free_count_next = free_count;
    low_water_next = low_water;
    mem_wr = '0;
    if (req_kind == KIND_GET) begin
      if (7'(free_count) > req_margin) begin
        grant = 1'b1;
        blk_res = free_head;
        free_count_next = free_count - CNT_W'(1);
        if (free_count_next < low_water) begin
          low_water_next = free_count_next;
        end
        // A link that is not a block index leaves the head at block 0.
        free_head_next = (rd_link < LINK_W'(BLOCKS)) ? rd_link[IDX_W-1:0] : '0;
        mem_wr.en = fire;
        mem_wr.addr = free_head;
        mem_wr.data = LINK_TAKEN;
      end else begin
        stat = STAT_MARGIN;
      end
    end else begin
      if (free_count < CNT_W'(BLOCKS)) begin
        grant = 1'b1;
        free_head_next = req_blk;
        free_count_next = free_count + CNT_W'(1);
        mem_wr.en = fire;
        mem_wr.addr = req_blk;
        mem_wr.data = (free_count == '0) ? LINK_NONE : LINK_W'(free_head);
      end else begin
        stat = STAT_FULL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_kind <= kind;
      req_margin <= margin;
      req_blk <= block_index;
    end
    if (fire) begin
      granted <= grant;
      block_out <= blk_res;
      status <= stat;
      free_now <= 7'(free_count_next);
      min_free <= 7'(low_water_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rsp_valid <= 1'b0;
      free_head <= '0;
      free_count <= CNT_W'(BLOCKS);
      low_water <= CNT_W'(BLOCKS);
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (fire) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (fire) begin
        rsp_valid <= 1'b1;
        free_head <= free_head_next;
        free_count <= free_count_next;
        low_water <= low_water_next;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (free_count <= CNT_W'(BLOCKS)) && (low_water <= free_count))
    else $error("free count or low-water mark out of range");

  a_grant_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (granted == (status == STAT_OK)))
    else $error("granted flag disagrees with status");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (fire && grant) |=> (free_count != $past(free_count)))
    else $error("granted transaction did not change the free count");

  a_head_stable: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC) && !fire |=> $stable(free_head) && (state == ST_EXEC))
    else $error("list head moved while the response was stalled");

endmodule

### rtl/fbpa_link_mem.sv
`timescale 1ns / 1ps

module fbpa_link_mem import fbpa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  mem_wr_t           wr,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_addr,
  output logic [LINK_W-1:0] rd_link
);

  logic [LINK_W-1:0] mem [BLOCKS];
  logic [BLOCKS-1:0] written;
  logic [LINK_W-1:0] rd_data;
  logic              rd_written;
  logic [IDX_W-1:0]  rd_addr_q;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  // One flag per entry tells a written link from its power-up value.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_written <= 1'b0;
    end else begin
      if (wr.en) begin
        written[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_written <= written[rd_addr];
      end
    end
  end

  assign rd_link = rd_written ? rd_data : reset_link(rd_addr_q);

  a_no_collision: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> !(wr.en && (wr.addr == rd_addr)))
    else $error("link memory read and write hit the same entry");

  a_written_sticks: assert property (@(posedge clk) disable iff (rst)
    wr.en |=> written[$past(wr.addr)])
    else $error("written flag not set after a write");

  a_read_flag: assert property (@(posedge clk) disable iff (rst)
    (rd_en && written[rd_addr] && !wr.en) |=> rd_written)
    else $error("read lost the written flag");

endmodule
